/* rtl/lcdstd_pkg.sv */
// ----------------------------------------------------------------------------
// lcdstd_pkg
// Shared codes, screen templates and helper functions for the LCD screen
// template decoder.
// ----------------------------------------------------------------------------
package lcdstd_pkg;

	// Screen geometry of a 16x2 character display.
	localparam int SCREEN_LEN = 32;
	localparam int LINE_LEN   = 16;
	localparam int POS_W      = 5;

	// Special character codes.
	localparam logic [7:0] CH_WILD      = 8'h7E;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_ALT_SPACE = 8'h80;

	// Request codes.
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_PROC  = 2'd2;

	// Screen kinds.
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_OFF    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_SETPT  = 2'd3;

	// Tri-state flag codes shared by power, cooling and alarm.
	localparam logic [1:0] FLAG_NO      = 2'd0;
	localparam logic [1:0] FLAG_YES     = 2'd1;
	localparam logic [1:0] FLAG_UNKNOWN = 2'd2;

	localparam logic [7:0] VAL_UNKNOWN = 8'hFF;

	// Full-screen templates; the first character sits in the top byte.
	localparam logic [8*SCREEN_LEN-1:0] TPL_OFF =
		"Unit is OFF     by I/O key      ";
	localparam logic [8*SCREEN_LEN-1:0] TPL_STATUS =
		" ~~~F    ~~ %RH ~~~~~~~~~       ";

	// Short templates, padded to 16 characters at the end.
	localparam int SETPT_LEN   = 10;
	localparam int COOL_LEN    = 7;
	localparam int NOALARM_LEN = 9;
	localparam logic [8*LINE_LEN-1:0] TPL_SETPT   = {"TEMP SETPT", 48'h0};
	localparam logic [8*LINE_LEN-1:0] TPL_COOL    = {"COOLING", 72'h0};
	localparam logic [8*LINE_LEN-1:0] TPL_NOALARM = {"NO ALARMS", 56'h0};

	// Flags and decoded values handed from the matcher to the sequencer.
	typedef struct packed {
		logic       off_ok;
		logic       status_ok;
		logic       setpt_ok;
		logic       cool_ok;
		logic       noalarm_ok;
		logic [7:0] temp;
		logic [7:0] hum;
		logic [7:0] setpt;
	} match_t;

	// Character k of a full-screen template.
	function automatic logic [7:0] full_char(input logic [8*SCREEN_LEN-1:0] tpl,
		input logic [POS_W-1:0] k);
		return tpl[{~k, 3'b000} +: 8];
	endfunction

	// Character k of a padded short template.
	function automatic logic [7:0] short_char(input logic [8*LINE_LEN-1:0] tpl,
		input logic [3:0] k);
		return tpl[{~k, 3'b000} +: 8];
	endfunction

	// A tilde on either side matches anything; a space and 0x80 are alike.
	function automatic logic chars_match(input logic [7:0] x, input logic [7:0] y);
		logic m;
		m = (x == y) || (x == CH_WILD) || (y == CH_WILD)
			|| ((x == CH_SPACE) && (y == CH_ALT_SPACE))
			|| ((x == CH_ALT_SPACE) && (y == CH_SPACE));
		return m;
	endfunction

	// Two ASCII digits to a value, modulo 256: d0*10 + d1 - 528, and -528 = 240 mod 256.
	function automatic logic [7:0] two_digits(input logic [7:0] d0, input logic [7:0] d1);
		logic [7:0] v;
		v = {d0[4:0], 3'b000} + {d0[6:0], 1'b0} + d1 + 8'd240;
		return v;
	endfunction

endpackage

/* rtl/lcd_screen_template_decoder_unit.sv */
// ----------------------------------------------------------------------------
// lcd_screen_template_decoder_unit
// Collects sniffed LCD characters per thermostat unit and decodes finished
// screens against fixed templates into power, cooling, alarm and readings.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  in        | in_valid / in_ready   | req_type, unit, char_code
//  out       | out_valid / out_ready | unit_out, screen_kind, power_state,
//            |                       | cooling_state, alarm_state, temperature,
//            |                       | humidity, setpoint
//
//  Start screen runs a 16-entry clearing sweep of the top line; process screen
//  takes the accept step, 32 buffer reads through the single memory read port,
//  the return of the last read data, then the status update.
//  Reset clears status to unknown and the buffer to zero at once.
//  One transaction is worked on at a time; a finished result waits in the output
//  register and holds the sequencer only if the previous result was not taken.
// ----------------------------------------------------------------------------
module lcd_screen_template_decoder_unit #(
	parameter int NUM_UNITS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic       unit,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       unit_out,
	output logic [1:0] screen_kind,
	output logic [1:0] power_state,
	output logic [1:0] cooling_state,
	output logic [1:0] alarm_state,
	output logic [7:0] temperature,
	output logic [7:0] humidity,
	output logic [7:0] setpoint
);
	import lcdstd_pkg::*;

	localparam int ADDR_W = $clog2(NUM_UNITS * SCREEN_LEN);
	localparam int UIDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       req_q;
	logic             unit_q;
	logic [5:0]       cnt_q;
	logic             rd_pend_s1;
	logic [POS_W-1:0] rd_pos_s1;

	logic [POS_W-1:0] write_pos_q [NUM_UNITS];
	logic [1:0]       power_q     [NUM_UNITS];
	logic [1:0]       cooling_q   [NUM_UNITS];
	logic [1:0]       alarm_q     [NUM_UNITS];
	logic [7:0]       temp_q      [NUM_UNITS];
	logic [7:0]       hum_q       [NUM_UNITS];
	logic [7:0]       setpt_q     [NUM_UNITS];

	logic             out_valid_q;
	logic             unit_out_q;
	logic [1:0]       kind_out_q, power_out_q, cooling_out_q, alarm_out_q;
	logic [7:0]       temp_out_q, hum_out_q, setpt_out_q;

	logic              accept, load;
	logic              in_range_in, in_range_q;
	logic [UIDX_W-1:0] uidx_in, uidx_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;
	match_t            match;

	logic [1:0] nxt_kind, nxt_power, nxt_cooling, nxt_alarm;
	logic [7:0] nxt_temp, nxt_hum, nxt_setpt;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign load        = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign uidx_in     = UIDX_W'(unit);
	assign uidx_q      = UIDX_W'(unit_q);
	assign in_range_in = (int'(unit) < NUM_UNITS);
	assign in_range_q  = (int'(unit_q) < NUM_UNITS);

	// Buffer write port: an added character, or zeros during the top-line sweep.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'({unit_q, 1'b0, cnt_q[3:0]});
		mem_wdata = 8'h00;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && (req_type == REQ_ADD) && in_range_in) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'({unit, write_pos_q[uidx_in]});
			mem_wdata = char_code;
		end
	end

	// Buffer read port walks the whole screen during a scan.
	assign mem_re    = (state_q == ST_SCAN) && !cnt_q[5];
	assign mem_raddr = ADDR_W'({unit_q, cnt_q[4:0]});

	lcdstd_screen_mem #(
		.NUM_UNITS(NUM_UNITS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lcdstd_tmpl_match u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (accept),
		.en    (rd_pend_s1),
		.pos   (rd_pos_s1),
		.ch    (mem_rdata),
		.result(match)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			req_q      <= REQ_START;
			unit_q     <= 1'b0;
			cnt_q      <= '0;
			rd_pend_s1 <= 1'b0;
			rd_pos_s1  <= '0;
		end else begin
			rd_pend_s1 <= mem_re;
			rd_pos_s1  <= cnt_q[4:0];
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q  <= req_type;
						unit_q <= unit;
						cnt_q  <= '0;
						if (in_range_in && (req_type == REQ_START)) begin
							state_q <= ST_CLEAR;
						end else if (in_range_in && (req_type == REQ_PROC)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[3:0] == 4'(LINE_LEN - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (!cnt_q[5]) begin
						cnt_q <= cnt_q + 6'd1;
					end
					if (rd_pend_s1 && (rd_pos_s1 == POS_W'(SCREEN_LEN - 1))) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Status update from the match flags of a processed screen.
	always_comb begin
		nxt_kind    = KIND_NONE;
		nxt_power   = power_q[uidx_q];
		nxt_cooling = cooling_q[uidx_q];
		nxt_alarm   = alarm_q[uidx_q];
		nxt_temp    = temp_q[uidx_q];
		nxt_hum     = hum_q[uidx_q];
		nxt_setpt   = setpt_q[uidx_q];
		if (req_q == REQ_PROC) begin
			if (match.off_ok) begin
				nxt_power = FLAG_NO;
				nxt_kind  = KIND_OFF;
			end else begin
				nxt_power = FLAG_YES;
				if (match.status_ok) begin
					nxt_temp = match.temp;
					nxt_hum  = match.hum;
					if (match.cool_ok) begin
						nxt_cooling = FLAG_YES;
					end else if (match.noalarm_ok) begin
						nxt_alarm = FLAG_NO;
					end
					nxt_kind = KIND_STATUS;
				end else if (match.setpt_ok) begin
					nxt_setpt = match.setpt;
					nxt_kind  = KIND_SETPT;
				end
			end
		end
	end

	// Per-unit status and write position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_UNITS; i++) begin
				write_pos_q[i] <= '0;
				power_q[i]     <= FLAG_UNKNOWN;
				cooling_q[i]   <= FLAG_UNKNOWN;
				alarm_q[i]     <= FLAG_UNKNOWN;
				temp_q[i]      <= VAL_UNKNOWN;
				hum_q[i]       <= VAL_UNKNOWN;
				setpt_q[i]     <= VAL_UNKNOWN;
			end
		end else begin
			if (accept && (req_type == REQ_ADD) && in_range_in) begin
				write_pos_q[uidx_in] <= write_pos_q[uidx_in] + 5'd1;
			end
			if ((state_q == ST_CLEAR) && (cnt_q[3:0] == 4'(LINE_LEN - 1))) begin
				write_pos_q[uidx_q] <= POS_W'(LINE_LEN);
			end
			if (load && in_range_q && (req_q == REQ_PROC)) begin
				power_q[uidx_q]   <= nxt_power;
				cooling_q[uidx_q] <= nxt_cooling;
				alarm_q[uidx_q]   <= nxt_alarm;
				temp_q[uidx_q]    <= nxt_temp;
				hum_q[uidx_q]     <= nxt_hum;
				setpt_q[uidx_q]   <= nxt_setpt;
			end
		end
	end

	// Output register; a unit outside the configured range reports unknowns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_out_q <= unit_q;
			if (in_range_q) begin
				kind_out_q    <= nxt_kind;
				power_out_q   <= nxt_power;
				cooling_out_q <= nxt_cooling;
				alarm_out_q   <= nxt_alarm;
				temp_out_q    <= nxt_temp;
				hum_out_q     <= nxt_hum;
				setpt_out_q   <= nxt_setpt;
			end else begin
				kind_out_q    <= KIND_NONE;
				power_out_q   <= FLAG_UNKNOWN;
				cooling_out_q <= FLAG_UNKNOWN;
				alarm_out_q   <= FLAG_UNKNOWN;
				temp_out_q    <= VAL_UNKNOWN;
				hum_out_q     <= VAL_UNKNOWN;
				setpt_out_q   <= VAL_UNKNOWN;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign unit_out      = unit_out_q;
	assign screen_kind   = kind_out_q;
	assign power_state   = power_out_q;
	assign cooling_state = cooling_out_q;
	assign alarm_state   = alarm_out_q;
	assign temperature   = temp_out_q;
	assign humidity      = hum_out_q;
	assign setpoint      = setpt_out_q;

	// A decoded screen always leaves the power state known.
	a_kind_power_known: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (screen_kind != KIND_NONE)) |-> (power_state != FLAG_UNKNOWN))
		else $error("decoded screen reported with unknown power state");

	// The off screen reports power off.
	a_off_is_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (screen_kind == KIND_OFF)) |-> (power_state == FLAG_NO))
		else $error("off screen reported with power not off");

	// Buffer reads return only while a scan is running.
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == ST_SCAN))
		else $error("buffer read data outside of a scan");

	// The clearing sweep stays within the top line.
	a_clear_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (cnt_q < 6'(LINE_LEN)))
		else $error("top-line sweep ran past the line");

endmodule

/* rtl/lcdstd_screen_mem.sv */
// ----------------------------------------------------------------------------
// lcdstd_screen_mem
// Character buffer of all units, one write and one registered read port,
// with per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module lcdstd_screen_mem #(
	parameter int NUM_UNITS = 2
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            we,
	input  logic [$clog2(NUM_UNITS*lcdstd_pkg::SCREEN_LEN)-1:0] waddr,
	input  logic [7:0]                                      wdata,
	input  logic                                            re,
	input  logic [$clog2(NUM_UNITS*lcdstd_pkg::SCREEN_LEN)-1:0] raddr,
	output logic [7:0]                                      rdata
);
	import lcdstd_pkg::*;

	localparam int DEPTH  = NUM_UNITS * SCREEN_LEN;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_data_q;
	logic             rd_valid_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	// An entry becomes valid on its first write; reset restores all-zero content.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : 8'h00;

endmodule

/* rtl/lcdstd_tmpl_match.sv */
// ----------------------------------------------------------------------------
// lcdstd_tmpl_match
// Shared character compare unit: takes one buffer character per cycle while
// en is high, checks it against every template and captures the digit positions.
// ----------------------------------------------------------------------------
module lcdstd_tmpl_match (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  logic                                en,
	input  logic [lcdstd_pkg::POS_W-1:0]        pos,
	input  logic [7:0]                          ch,
	output lcdstd_pkg::match_t                  result
);
	import lcdstd_pkg::*;

	logic       off_q, status_q, setpt_q, cool_q, noalarm_q;
	logic [7:0] d1_q, d2_q, d9_q, d10_q, d12_q, d13_q;
	logic       in_setpt, in_cool, in_noalarm;
	logic       m_off, m_status, m_setpt, m_cool, m_noalarm;

	// Which short templates cover this position.
	assign in_setpt   = !pos[4] && (pos[3:0] < 4'(SETPT_LEN));
	assign in_cool    = pos[4] && (pos[3:0] < 4'(COOL_LEN));
	assign in_noalarm = pos[4] && (pos[3:0] < 4'(NOALARM_LEN));

	// One compare per template for the current character.
	assign m_off     = chars_match(ch, full_char(TPL_OFF, pos));
	assign m_status  = chars_match(ch, full_char(TPL_STATUS, pos));
	assign m_setpt   = !in_setpt || chars_match(ch, short_char(TPL_SETPT, pos[3:0]));
	assign m_cool    = !in_cool || chars_match(ch, short_char(TPL_COOL, pos[3:0]));
	assign m_noalarm = !in_noalarm || chars_match(ch, short_char(TPL_NOALARM, pos[3:0]));

	// Running match flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= 1'b1;
			status_q  <= 1'b1;
			setpt_q   <= 1'b1;
			cool_q    <= 1'b1;
			noalarm_q <= 1'b1;
		end else if (clear) begin
			off_q     <= 1'b1;
			status_q  <= 1'b1;
			setpt_q   <= 1'b1;
			cool_q    <= 1'b1;
			noalarm_q <= 1'b1;
		end else if (en) begin
			off_q     <= off_q & m_off;
			status_q  <= status_q & m_status;
			setpt_q   <= setpt_q & m_setpt;
			cool_q    <= cool_q & m_cool;
			noalarm_q <= noalarm_q & m_noalarm;
		end
	end

	// Digit capture for temperature, humidity and set point.
	always_ff @(posedge clk) begin
		if (en) begin
			case (pos)
				5'd1: begin
					d1_q <= ch;
				end
				5'd2: begin
					d2_q <= ch;
				end
				5'd9: begin
					d9_q <= ch;
				end
				5'd10: begin
					d10_q <= ch;
				end
				5'd12: begin
					d12_q <= ch;
				end
				5'd13: begin
					d13_q <= ch;
				end
				default: begin
				end
			endcase
		end
	end

	assign result.off_ok     = off_q;
	assign result.status_ok  = status_q;
	assign result.setpt_ok   = setpt_q;
	assign result.cool_ok    = cool_q;
	assign result.noalarm_ok = noalarm_q;
	assign result.temp       = two_digits(d1_q, d2_q);
	assign result.hum        = two_digits(d9_q, d10_q);
	assign result.setpt      = two_digits(d12_q, d13_q);

endmodule

/* tb/sv/tb_lcd_screen_template_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_screen_template_decoder_unit
// Self-checking testbench for the LCD screen template decoder. Whole screens
// and loose requests are sent to both thermostat units. A shadow decoder
// inside the bench predicts the status carried by every transaction, and a
// checker compares each result field by field. Random gaps on the request
// side and stalls on the result side are mixed into the test.
// ----------------------------------------------------------------------------
module tb_lcd_screen_template_decoder_unit;

	import lcdstd_pkg::*;

	localparam int UNIT_COUNT   = 2;
	localparam int RANDOM_ITEMS = 780;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE_TIME  = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int REPORT_LIMIT = 40;

	// Request code with no defined action.
	localparam logic [1:0] REQ_NOP = 2'd3;

	// Character codes with a special meaning while matching.
	localparam logic [7:0] GLYPH_WILD      = 8'h7E;
	localparam logic [7:0] GLYPH_SPACE     = 8'h20;
	localparam logic [7:0] GLYPH_ALT_SPACE = 8'h80;
	localparam logic [7:0] GLYPH_ZERO      = 8'h30;

	// Screen images; character 0 sits in the top byte.
	localparam logic [255:0] OFF_IMG    = "Unit is OFF     by I/O key      ";
	localparam logic [255:0] STATUS_IMG = " ~~~F    ~~ %RH ~~~~~~~~~       ";
	localparam logic [79:0]  SETPT_TAG   = "TEMP SETPT";
	localparam logic [55:0]  COOL_TAG    = "COOLING";
	localparam logic [71:0]  NOALARM_TAG = "NO ALARMS";

	typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PATTERN} rx_mode_t;
	typedef enum int {
		SCR_OFF, SCR_COOL, SCR_NOALARM, SCR_PLAIN, SCR_SETPT, SCR_JUNK
	} screen_style_t;

	typedef struct packed {
		logic [1:0] code;
		logic       unit_id;
		logic [7:0] ch;
	} request_t;

	typedef struct packed {
		logic       unit_id;
		logic [1:0] kind;
		logic [1:0] power;
		logic [1:0] cooling;
		logic [1:0] alarm;
		logic [7:0] temp;
		logic [7:0] hum;
		logic [7:0] setpt;
	} status_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic       unit;
	logic [7:0] char_code;
	logic       out_valid;
	logic       out_ready;
	logic       unit_out;
	logic [1:0] screen_kind;
	logic [1:0] power_state;
	logic [1:0] cooling_state;
	logic [1:0] alarm_state;
	logic [7:0] temperature;
	logic [7:0] humidity;
	logic [7:0] setpoint;

	// Shadow copy of the per-unit decoder state.
	logic [7:0] shadow_chars [UNIT_COUNT][SCREEN_LEN];
	logic [4:0] shadow_pos  [UNIT_COUNT];
	logic [1:0] power_now   [UNIT_COUNT];
	logic [1:0] cooling_now [UNIT_COUNT];
	logic [1:0] alarm_now   [UNIT_COUNT];
	logic [7:0] temp_now    [UNIT_COUNT];
	logic [7:0] hum_now     [UNIT_COUNT];
	logic [7:0] setpt_now   [UNIT_COUNT];

	status_t  pending_status[$];
	request_t plan_a[$];
	request_t plan_b[$];

	int       err_count   = 0;
	int       sent_count  = 0;
	int       result_count = 0;
	int       off_seen    = 0;
	int       status_seen = 0;
	int       setpt_seen  = 0;
	int       burst_left  = 0;
	logic     tx_gaps_on  = 1'b1;
	logic     rx_hold_req = 1'b0;
	rx_mode_t rx_mode     = RX_FREE;

	lcd_screen_template_decoder_unit #(
		.NUM_UNITS(UNIT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.unit(unit),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.unit_out(unit_out),
		.screen_kind(screen_kind),
		.power_state(power_state),
		.cooling_state(cooling_state),
		.alarm_state(alarm_state),
		.temperature(temperature),
		.humidity(humidity),
		.setpoint(setpoint)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow decoder
	// ------------------------------------------------------------------------

	// A tilde on either side matches anything; a space and 0x80 are alike.
	function automatic logic glyph_eq(input logic [7:0] x, input logic [7:0] y);
		if (x == GLYPH_WILD || y == GLYPH_WILD)
			return 1'b1;
		if ((x == GLYPH_SPACE && y == GLYPH_ALT_SPACE) ||
			(x == GLYPH_ALT_SPACE && y == GLYPH_SPACE))
			return 1'b1;
		return x == y;
	endfunction

	// Compares n buffer characters from position first with a right-aligned tag.
	function automatic logic span_fits(input logic u, input int first,
		input logic [255:0] tag, input int n);
		int k;
		for (k = 0; k < n; k++) begin
			if (!glyph_eq(shadow_chars[u][first + k], tag[8 * (n - 1 - k) +: 8]))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Two character codes read as a decimal pair, wrapped to eight bits.
	function automatic logic [7:0] decimal_pair(input logic [7:0] d0, input logic [7:0] d1);
		int v;
		v = int'(d0) * 10 + int'(d1) - int'(GLYPH_ZERO) * 11;
		return v[7:0];
	endfunction

	// Applies one request to the shadow state and returns the status it reports.
	function automatic status_t predict_status(input logic [1:0] code, input logic u,
		input logic [7:0] ch);
		status_t    s;
		logic [1:0] kind;
		int         k;
		kind = KIND_NONE;
		if (code == REQ_START) begin
			for (k = 0; k < LINE_LEN; k++)
				shadow_chars[u][k] = 8'h00;
			shadow_pos[u] = 5'(LINE_LEN);
		end else if (code == REQ_ADD) begin
			shadow_chars[u][shadow_pos[u]] = ch;
			shadow_pos[u] = shadow_pos[u] + 5'd1;
		end else if (code == REQ_PROC) begin
			if (span_fits(u, 0, OFF_IMG, SCREEN_LEN)) begin
				power_now[u] = FLAG_NO;
				kind = KIND_OFF;
			end else begin
				power_now[u] = FLAG_YES;
				if (span_fits(u, 0, STATUS_IMG, SCREEN_LEN)) begin
					temp_now[u] = decimal_pair(shadow_chars[u][1], shadow_chars[u][2]);
					hum_now[u] = decimal_pair(shadow_chars[u][9], shadow_chars[u][10]);
					if (span_fits(u, LINE_LEN, COOL_TAG, 7))
						cooling_now[u] = FLAG_YES;
					else if (span_fits(u, LINE_LEN, NOALARM_TAG, 9))
						alarm_now[u] = FLAG_NO;
					kind = KIND_STATUS;
				end else if (span_fits(u, 0, SETPT_TAG, 10)) begin
					setpt_now[u] = decimal_pair(shadow_chars[u][12], shadow_chars[u][13]);
					kind = KIND_SETPT;
				end
			end
		end
		s.unit_id = u;
		s.kind    = kind;
		s.power   = power_now[u];
		s.cooling = cooling_now[u];
		s.alarm   = alarm_now[u];
		s.temp    = temp_now[u];
		s.hum     = hum_now[u];
		s.setpt   = setpt_now[u];
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Screen images
	// ------------------------------------------------------------------------

	function automatic logic [7:0] char_at(input logic [255:0] img, input int p);
		return img[8 * (SCREEN_LEN - 1 - p) +: 8];
	endfunction

	function automatic logic [255:0] with_char(input logic [255:0] img, input int p,
		input logic [7:0] c);
		img[8 * (SCREEN_LEN - 1 - p) +: 8] = c;
		return img;
	endfunction

	// Mostly a decimal digit, now and then any code at all.
	function automatic logic [7:0] pick_digit();
		if ($urandom_range(0, 9) != 0)
			return GLYPH_ZERO + 8'($urandom_range(0, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	// Builds a random screen of the given style; all but junk get small defects.
	function automatic logic [255:0] random_screen(input screen_style_t style);
		logic [255:0] img;
		logic [7:0]   c;
		int           p;
		for (p = 0; p < SCREEN_LEN; p++)
			img = with_char(img, p, 8'($urandom_range(0, 255)));
		if (style == SCR_JUNK)
			return img;
		case (style)
			SCR_OFF: img = OFF_IMG;
			SCR_SETPT: begin
				img[255 -: 80] = SETPT_TAG;
				img = with_char(img, 12, pick_digit());
				img = with_char(img, 13, pick_digit());
			end
			default: begin
				c = char_at(img, 3);
				img = with_char(img, 16, char_at(img, 20));
				img[127 -: 72] = img[127 -: 72];
				img = {STATUS_IMG[255:128], img[127:56], STATUS_IMG[55:0]};
				img = with_char(img, 1, pick_digit());
				img = with_char(img, 2, pick_digit());
				img = with_char(img, 3, c);
				img = with_char(img, 9, pick_digit());
				img = with_char(img, 10, pick_digit());
				if (style == SCR_COOL)
					img[127 -: 56] = COOL_TAG;
				else if (style == SCR_NOALARM)
					img[127 -: 72] = NOALARM_TAG;
			end
		endcase
		// Alternate spaces, stray tildes and the odd corrupted character.
		for (p = 0; p < SCREEN_LEN; p++) begin
			c = char_at(img, p);
			if (c == GLYPH_SPACE && $urandom_range(0, 2) == 0)
				c = GLYPH_ALT_SPACE;
			else if ($urandom_range(0, 47) == 0)
				c = GLYPH_WILD;
			img = with_char(img, p, c);
		end
		if ($urandom_range(0, 5) == 0) begin
			p = $urandom_range(0, SCREEN_LEN - 1);
			img = with_char(img, p, 8'($urandom_range(0, 255)));
		end
		return img;
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offers one request in bursts with random gaps and waits for its transaction.
	task automatic issue_request(input logic [1:0] code, input logic u, input logic [7:0] ch);
		int gap;
		if (tx_gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 6);
			if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(10, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid  <= 1'b1;
		req_type  <= code;
		unit      <= u;
		char_code <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_status.push_back(predict_status(code, u, ch));
		sent_count++;
	endtask

	// Holds the request side idle until every expected status has come back.
	task automatic wait_for_results();
		int spins;
		spins = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			spins++;
		end while (pending_status.size() != 0 && spins < DRAIN_LIMIT);
		if (pending_status.size() != 0) begin
			err_count++;
			$display("%0t ns: %0d results never arrived", $time, pending_status.size());
		end
		burst_left = 0;
	endtask

	function automatic void plan_push(input logic u, input logic [1:0] code,
		input logic [7:0] ch);
		request_t r;
		r.code    = code;
		r.unit_id = u;
		r.ch      = ch;
		if (u)
			plan_b.push_back(r);
		else
			plan_a.push_back(r);
	endfunction

	// Queues a screen for one unit: start, nchars characters from the bottom
	// line on (repeating the image past 32), then optionally a process request.
	task automatic plan_screen(input logic u, input logic [255:0] img, input int nchars,
		input logic with_proc);
		int i;
		plan_push(u, REQ_START, 8'($urandom_range(0, 255)));
		for (i = 0; i < nchars; i++)
			plan_push(u, REQ_ADD, char_at(img, (LINE_LEN + i) % SCREEN_LEN));
		if (with_proc)
			plan_push(u, REQ_PROC, 8'($urandom_range(0, 255)));
	endtask

	// Sends the queued requests of both units, interleaved or one unit after the other.
	task automatic flush_plans(input logic interleave);
		request_t r;
		while (plan_a.size() != 0 || plan_b.size() != 0) begin
			if (plan_b.size() == 0 ||
				(plan_a.size() != 0 && (!interleave || $urandom_range(0, 1) == 0)))
				r = plan_a.pop_front();
			else
				r = plan_b.pop_front();
			issue_request(r.code, r.unit_id, r.ch);
		end
	endtask

	task automatic show_screen(input logic u, input logic [255:0] img);
		plan_screen(u, img, SCREEN_LEN, 1'b1);
		flush_plans(1'b0);
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// Receiver stall pattern, with a long hold-off on request.
	initial begin : rx_pacing
		int hold_left;
		int phase;
		hold_left = 0;
		phase = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			phase++;
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:   out_ready <= 1'b1;
					RX_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= ((phase % 7) < 4);
				endcase
			end
		end
	end

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			err_count++;
			if (err_count <= REPORT_LIMIT)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, what, want, got);
		end
	endtask

	// Compares every result transaction with the oldest expected status.
	always @(posedge clk) begin : result_check
		status_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			case (screen_kind)
				KIND_OFF:    off_seen++;
				KIND_STATUS: status_seen++;
				KIND_SETPT:  setpt_seen++;
				default: ;
			endcase
			if (pending_status.size() == 0) begin
				err_count++;
				$display("%0t ns: result with no request waiting, expected none, actual unit %0d",
					$time, unit_out);
			end else begin
				want = pending_status.pop_front();
				check_field("unit_out", want.unit_id, unit_out);
				check_field("screen_kind", want.kind, screen_kind);
				check_field("power_state", want.power, power_state);
				check_field("cooling_state", want.cooling, cooling_state);
				check_field("alarm_state", want.alarm, alarm_state);
				check_field("temperature", want.temp, temperature);
				check_field("humidity", want.hum, humidity);
				check_field("setpoint", want.setpt, setpoint);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Status straight after reset, the undefined request code and a character
	// written before any screen was started.
	task automatic test_power_on_status();
		issue_request(REQ_NOP, 1'b0, 8'hA5);
		issue_request(REQ_PROC, 1'b1, 8'h00);
		issue_request(REQ_ADD, 1'b0, 8'hFF);
		issue_request(REQ_NOP, 1'b1, 8'h5A);
		issue_request(REQ_START, 1'b0, 8'h00);
		issue_request(REQ_PROC, 1'b0, 8'hFF);
		wait_for_results();
	endtask

	// Off screen, as drawn and with alternate spaces and tildes, plus a near miss.
	task automatic test_off_screen();
		logic [255:0] img;
		show_screen(1'b0, OFF_IMG);
		img = with_char(OFF_IMG, 5, GLYPH_ALT_SPACE);
		img = with_char(img, 8, GLYPH_ALT_SPACE);
		img = with_char(img, 30, GLYPH_ALT_SPACE);
		img = with_char(img, 2, GLYPH_WILD);
		img = with_char(img, 20, GLYPH_WILD);
		show_screen(1'b1, img);
		show_screen(1'b0, with_char(OFF_IMG, 0, "u"));
		wait_for_results();
	endtask

	// Status screens: cooling, no alarms, neither, and digits at the code extremes.
	// Cooling must stay set and alarms must never be raised again.
	task automatic test_status_screens();
		logic [255:0] img;
		img = with_char(STATUS_IMG, 1, "7");
		img = with_char(img, 2, "2");
		img = with_char(img, 3, GLYPH_SPACE);
		img = with_char(img, 9, "4");
		img = with_char(img, 10, "5");
		img[127 -: 56] = COOL_TAG;
		show_screen(1'b0, img);
		img[127 -: 72] = NOALARM_TAG;
		img = with_char(img, 1, "9");
		img = with_char(img, 2, "9");
		img = with_char(img, 9, "0");
		img = with_char(img, 10, "0");
		show_screen(1'b0, img);
		img[127 -: 72] = "XYZ      ";
		img = with_char(img, 1, 8'h00);
		img = with_char(img, 2, 8'hFF);
		img = with_char(img, 9, 8'hFF);
		img = with_char(img, 10, 8'h00);
		show_screen(1'b0, img);
		img[127 -: 72] = NOALARM_TAG;
		img = with_char(img, 1, GLYPH_WILD);
		show_screen(1'b1, img);
		img[127 -: 56] = COOL_TAG;
		show_screen(1'b1, img);
		wait_for_results();
	endtask

	// Setpoint screens with plain and alternate spaces, and a tag that misses.
	task automatic test_setpoint_screen();
		logic [255:0] img;
		img = {SETPT_TAG, "  68  ", 128'h0};
		show_screen(1'b1, img);
		img = with_char(img, 4, GLYPH_ALT_SPACE);
		img = with_char(img, 12, "0");
		img = with_char(img, 13, "0");
		show_screen(1'b0, img);
		show_screen(1'b0, with_char(img, 9, "X"));
		wait_for_results();
	endtask

	// More than a screen of characters: the write position wraps and
	// overwrites the bottom line, then the top line, in order.
	task automatic test_wraparound();
		plan_screen(1'b0, OFF_IMG, 2 * SCREEN_LEN, 1'b1);
		plan_screen(1'b1, OFF_IMG, SCREEN_LEN + 5, 1'b1);
		flush_plans(1'b1);
		wait_for_results();
	endtask

	// The receiver holds off for a long stretch while requests keep coming,
	// so the decoder fills and stalls its input.
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_mode = RX_FREE;
		rx_hold_req = 1'b1;
		show_screen(1'b1, random_screen(SCR_COOL));
		wait_for_results();
		tx_gaps_on = 1'b1;
	endtask

	// Mostly well-formed screens with random content on both units, with
	// broken screens and loose noise requests mixed in.
	task automatic test_random_traffic();
		int   first;
		int   pick;
		int   n;
		int   k;
		logic u;
		logic paused;
		first = sent_count;
		paused = 1'b0;
		while (sent_count - first < RANDOM_ITEMS) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			u = 1'($urandom_range(0, 1));
			if (pick < 7) begin
				plan_screen(u, random_screen(screen_style_t'($urandom_range(0, 5))),
					SCREEN_LEN, 1'b1);
				if ($urandom_range(0, 1))
					plan_screen(!u, random_screen(screen_style_t'($urandom_range(0, 5))),
						SCREEN_LEN, 1'b1);
				flush_plans(1'($urandom_range(0, 1)));
			end else if (pick < 9) begin
				plan_screen(u, random_screen(screen_style_t'($urandom_range(0, 5))),
					$urandom_range(0, 2 * SCREEN_LEN), 1'($urandom_range(0, 1)));
				flush_plans(1'b0);
			end else begin
				n = $urandom_range(1, 8);
				for (k = 0; k < n; k++)
					issue_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
			end
			// Once midway, pause the request side until the decoder is empty.
			if (!paused && sent_count - first > RANDOM_ITEMS / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin : run_tests
		int u;
		int k;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		req_type  <= REQ_START;
		unit      <= 1'b0;
		char_code <= 8'h00;
		for (u = 0; u < UNIT_COUNT; u++) begin
			for (k = 0; k < SCREEN_LEN; k++)
				shadow_chars[u][k] = 8'h00;
			shadow_pos[u]  = 5'd0;
			power_now[u]   = FLAG_UNKNOWN;
			cooling_now[u] = FLAG_UNKNOWN;
			alarm_now[u]   = FLAG_UNKNOWN;
			temp_now[u]    = VAL_UNKNOWN;
			hum_now[u]     = VAL_UNKNOWN;
			setpt_now[u]   = VAL_UNKNOWN;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_status();
		test_off_screen();
		test_status_screens();
		test_setpoint_screen();
		test_wraparound();
		test_backpressure();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_TIME) @(posedge clk);
		$display("Sent %0d requests to both units and checked %0d results.",
			sent_count, result_count);
		$display("Screens decoded: %0d off, %0d status, %0d setpoint; %0d mismatches.",
			off_seen, status_seen, setpt_seen, err_count);
		if (err_count == 0)
			$display("lcd_screen_template_decoder_unit verification clean");
		else
			$display("lcd_screen_template_decoder_unit verification failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#10_000_000;
		$display("Timeout with %0d results outstanding.", pending_status.size());
		$display("lcd_screen_template_decoder_unit verification failed");
		$finish;
	end

endmodule
